FILE: hw/rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and constants for the stable sorted priority queue
// Sizes, command and status codes, the stored entry layout, the sequencer
// state encoding and the key ordering function.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int TAG_BITS = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic        [TAG_BITS-1:0] tag_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic        [IDX_W-1:0]    idx_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SRCH_RD = 9'b000000010,
    S_SRCH_EV = 9'b000000100,
    S_SHDN_RD = 9'b000001000,
    S_SHDN_WR = 9'b000010000,
    S_SHUP_RD = 9'b000100000,
    S_SHUP_WR = 9'b001000000,
    S_PUT     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  // True when a fresh key must be placed in front of a held key.
  function automatic logic key_before(key_t fresh, key_t held, logic largest_first);
    logic r;
    if (largest_first) begin
      r = fresh > held;
    end else begin
      r = fresh < held;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sspq_if.sv
// ----------------------------------------------------------------------------
// sspq_if: request and response channels of the priority queue
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface sspq_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  sspq_pkg::key_t      key;
  sspq_pkg::tag_t      tag;

  modport source (output valid, output cmd, output key, output tag, input ready);
  modport sink   (input valid, input cmd, input key, input tag, output ready);
endinterface

interface sspq_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  sspq_pkg::key_t      out_key;
  sspq_pkg::tag_t      out_tag;
  sspq_pkg::cnt_t      fill;

  modport source (output valid, output status, output out_key, output out_tag,
                  output fill, input ready);
  modport sink   (input valid, input status, input out_key, input out_tag,
                  input fill, output ready);
endinterface

FILE: hw/rtl/sspq_ram.sv
// ----------------------------------------------------------------------------
// sspq_ram: entry store of the priority queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sspq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/stable_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core: bounded sorted priority queue
// Sequencer over an entry store with one write and one read port and one key/tag comparator.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: insert (key, tag), dequeue the
//   head, or delete the first entry with a given tag. rsp returns one result
//   per command: status, removed key and tag (zero unless removed), and the
//   fill level after the command. order_mode (cfg_we/cfg_wdata) picks
//   smallest-first (0) or largest-first (1); write it only while idle.
//   Equal keys leave in arrival order.
// Timing:
//   req.ready is high only while the sequencer is idle. Every step reads one
//   entry through the registered read port: the search visits entries in
//   order, each in a read and an evaluate state, and the shift moves entries
//   one at a time, each in a read and a write state. Empty, full and unused
//   commands go straight to the result state.
//   A result waits in the output register while rsp.ready is low; the next
//   command is accepted meanwhile and holds in its last state until the
//   register frees up.
// Reset: rst empties the queue and sets order_mode to smallest-first.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  sspq_req_if.sink        req,
  sspq_rsp_if.source      rsp
);

  sspq_pkg::state_t  state;
  logic              order_mode;
  sspq_pkg::cmd_t    cmd_r;
  sspq_pkg::key_t    key_r;
  sspq_pkg::tag_t    tag_r;
  sspq_pkg::cnt_t    idx;
  sspq_pkg::cnt_t    pos;
  sspq_pkg::cnt_t    count;
  sspq_pkg::status_t status_r;
  sspq_pkg::key_t    hit_key;
  sspq_pkg::tag_t    hit_tag;

  logic              rsp_valid;
  sspq_pkg::status_t rsp_status;
  sspq_pkg::key_t    rsp_key;
  sspq_pkg::tag_t    rsp_tag;
  sspq_pkg::cnt_t    rsp_fill;

  logic                          ram_we;
  sspq_pkg::idx_t                ram_waddr;
  logic [sspq_pkg::ENTRY_W-1:0]  ram_wdata;
  sspq_pkg::idx_t                ram_raddr;
  logic [sspq_pkg::ENTRY_W-1:0]  ram_rdata;

  sspq_pkg::entry_t  rd_entry;
  sspq_pkg::entry_t  new_entry;
  sspq_pkg::cmd_t    req_cmd;
  logic              match;
  sspq_pkg::cnt_t    idx_inc;
  sspq_pkg::cnt_t    idx_dec;
  logic [sspq_pkg::CNT_W:0] idx_plus2;
  logic              accept;

  sspq_ram #(
    .DEPTH (sspq_pkg::CAPACITY),
    .WIDTH (sspq_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and shared compare unit
  assign req.ready = (state == sspq_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign req_cmd   = sspq_pkg::cmd_t'(req.cmd);
  assign rd_entry  = sspq_pkg::entry_t'(ram_rdata);
  assign new_entry = '{key: key_r, tag: tag_r};
  assign idx_inc   = idx + 1'b1;
  assign idx_dec   = idx - 1'b1;
  assign idx_plus2 = {1'b0, idx} + (sspq_pkg::CNT_W + 1)'(2);

  always_comb begin
    if (cmd_r == sspq_pkg::CMD_INSERT) begin
      match = sspq_pkg::key_before(key_r, rd_entry.key, order_mode);
    end else begin
      match = (cmd_r == sspq_pkg::CMD_DEQUEUE) || (rd_entry.tag == tag_r);
    end
  end

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[sspq_pkg::IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[sspq_pkg::IDX_W-1:0];
    unique case (state)
      sspq_pkg::S_SHUP_RD: begin
        ram_raddr = idx_inc[sspq_pkg::IDX_W-1:0];
      end
      sspq_pkg::S_SHDN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc[sspq_pkg::IDX_W-1:0];
      end
      sspq_pkg::S_SHUP_WR: begin
        ram_we    = 1'b1;
      end
      sspq_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos[sspq_pkg::IDX_W-1:0];
        ram_wdata = new_entry;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sspq_pkg::S_IDLE;
      count      <= '0;
      order_mode <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      // drop the result once taken, unless a new one replaces it
      if (rsp_valid && rsp.ready && (state != sspq_pkg::S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        sspq_pkg::S_IDLE: begin
          if (accept) begin
            cmd_r    <= req_cmd;
            key_r    <= req.key;
            tag_r    <= req.tag;
            hit_key  <= '0;
            hit_tag  <= '0;
            idx      <= '0;
            pos      <= '0;
            case (req_cmd)
              sspq_pkg::CMD_INSERT: begin
                if (count == sspq_pkg::CNT_W'(sspq_pkg::CAPACITY)) begin
                  status_r <= sspq_pkg::ST_FULL;
                  state    <= sspq_pkg::S_DONE;
                end else if (count == '0) begin
                  status_r <= sspq_pkg::ST_OK;
                  state    <= sspq_pkg::S_PUT;
                end else begin
                  status_r <= sspq_pkg::ST_OK;
                  state    <= sspq_pkg::S_SRCH_RD;
                end
              end
              sspq_pkg::CMD_DEQUEUE, sspq_pkg::CMD_DELETE: begin
                if (count == '0) begin
                  status_r <= sspq_pkg::ST_EMPTY;
                  state    <= sspq_pkg::S_DONE;
                end else begin
                  status_r <= sspq_pkg::ST_OK;
                  state    <= sspq_pkg::S_SRCH_RD;
                end
              end
              default: begin
                status_r <= sspq_pkg::ST_OK;
                state    <= sspq_pkg::S_DONE;
              end
            endcase
          end
        end
        sspq_pkg::S_SRCH_RD: begin
          state <= sspq_pkg::S_SRCH_EV;
        end
        sspq_pkg::S_SRCH_EV: begin
          if (match) begin
            pos <= idx;
            if (cmd_r == sspq_pkg::CMD_INSERT) begin
              // shift the tail down from the last entry
              idx   <= count - 1'b1;
              state <= sspq_pkg::S_SHDN_RD;
            end else begin
              hit_key <= rd_entry.key;
              hit_tag <= rd_entry.tag;
              if (idx_inc < count) begin
                state <= sspq_pkg::S_SHUP_RD;
              end else begin
                count <= count - 1'b1;
                state <= sspq_pkg::S_DONE;
              end
            end
          end else if (idx_inc == count) begin
            if (cmd_r == sspq_pkg::CMD_INSERT) begin
              pos   <= count;
              state <= sspq_pkg::S_PUT;
            end else begin
              status_r <= sspq_pkg::ST_NOT_FOUND;
              state    <= sspq_pkg::S_DONE;
            end
          end else begin
            idx   <= idx_inc;
            state <= sspq_pkg::S_SRCH_RD;
          end
        end
        sspq_pkg::S_SHDN_RD: begin
          state <= sspq_pkg::S_SHDN_WR;
        end
        sspq_pkg::S_SHDN_WR: begin
          if (idx == pos) begin
            state <= sspq_pkg::S_PUT;
          end else begin
            idx   <= idx_dec;
            state <= sspq_pkg::S_SHDN_RD;
          end
        end
        sspq_pkg::S_SHUP_RD: begin
          state <= sspq_pkg::S_SHUP_WR;
        end
        sspq_pkg::S_SHUP_WR: begin
          if (idx_plus2 < {1'b0, count}) begin
            idx   <= idx_inc;
            state <= sspq_pkg::S_SHUP_RD;
          end else begin
            count <= count - 1'b1;
            state <= sspq_pkg::S_DONE;
          end
        end
        sspq_pkg::S_PUT: begin
          count <= count + 1'b1;
          state <= sspq_pkg::S_DONE;
        end
        sspq_pkg::S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status_r;
            rsp_key    <= hit_key;
            rsp_tag    <= hit_tag;
            rsp_fill   <= count;
            state      <= sspq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sspq_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.out_key = rsp_key;
  assign rsp.out_tag = rsp_tag;
  assign rsp.fill    = rsp_fill;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sspq_pkg::CNT_W'(sspq_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_put_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == sspq_pkg::S_PUT) |-> (count < sspq_pkg::CNT_W'(sspq_pkg::CAPACITY)))
    else $error("write of new entry into a full queue");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sspq_pkg::S_SRCH_RD) |-> (idx < count))
    else $error("search index beyond held entries");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == sspq_pkg::S_DONE && rsp_valid && !rsp.ready)
      |=> (state == sspq_pkg::S_DONE && rsp_valid))
    else $error("pending result overwritten");

endmodule
